// ----- rtl/core/shdt_pkg.sv -----
// Package for the string hash direct table: sizes, operation and register
// codes, the command passed from front to back, and the back-end states.
// No dependencies.
package shdt_pkg;

  localparam int TABLE_DEPTH  = 1024;
  localparam int VALUE_WIDTH  = 64;
  localparam int SLOT_W       = $clog2(TABLE_DEPTH);
  localparam int SLOT_OUT_W   = 10;
  localparam int SIZE_W       = 11;
  localparam int HASH_W       = 64;
  localparam int BYTE_W       = 8;
  localparam int OP_W         = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int DIV_BITS     = 8;
  localparam int DIV_STEPS    = HASH_W / DIV_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int CMDQ_DEPTH   = 2;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);
  localparam int TABLE_SIZE_RESET = 1024;

  localparam logic [OP_W-1:0] OP_SET     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_PTR = 3'd1;
  localparam logic [OP_W-1:0] OP_GET     = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_PTR = 3'd3;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTER_MODE = 1'b1;

  typedef struct packed {
    logic [HASH_W-1:0]      hash;
    logic [OP_W-1:0]        op;
    logic [VALUE_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DIV,
    BK_ACCESS,
    BK_FILL,
    BK_DONE
  } back_state_t;

endpackage

// ----- rtl/core/shdt_if.sv -----
// Valid/ready channel interfaces for name bytes in and results out.
// Depends on shdt_pkg.
interface shdt_in_if;
  logic                             valid;
  logic                             ready;
  logic [shdt_pkg::OP_W-1:0]        op;
  logic [shdt_pkg::BYTE_W-1:0]      name_byte;
  logic [63:0]                      write_value;

  modport source (output valid, op, name_byte, write_value, input ready);
  modport sink (input valid, op, name_byte, write_value, output ready);
endinterface

interface shdt_out_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [63:0]                      read_value;
  logic [shdt_pkg::SLOT_OUT_W-1:0]  slot;

  modport source (output valid, ok, read_value, slot, input ready);
  modport sink (input valid, ok, read_value, slot, output ready);
endinterface

// ----- rtl/core/shdt_front.sv -----
// Front end: accepts name bytes, folds them into the hash and queues a command
// on the terminating byte. Depends on shdt_pkg and shdt_in_if.
module shdt_front (
  input  logic                clk,
  input  logic                rst,
  shdt_in_if.sink             req,
  input  shdt_pkg::q_status_t q_stat,
  input  logic                clearing,
  output logic                push,
  output shdt_pkg::cmd_t      push_cmd
);
  import shdt_pkg::*;

  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] hash_next;
  logic              accept;

  assign req.ready = !clearing && !q_stat.full;
  assign accept    = req.valid && req.ready;
  assign push      = accept && (req.name_byte == '0);
  assign hash_next = (hash << 6) + (hash << 5) + hash + HASH_W'(req.name_byte);

  assign push_cmd.hash  = hash;
  assign push_cmd.op    = req.op;
  assign push_cmd.value = VALUE_WIDTH'(req.write_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (accept) begin
      hash <= (req.name_byte == '0) ? '0 : hash_next;
    end
  end

endmodule

// ----- rtl/core/shdt_cmdq.sv -----
// Short command queue between the front and back ends.
// Depends on shdt_pkg.
module shdt_cmdq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  shdt_pkg::cmd_t      wdata,
  input  logic                pop,
  output shdt_pkg::cmd_t      head,
  output shdt_pkg::q_status_t stat
);
  import shdt_pkg::*;

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr;
  logic [CMDQ_PTR_W-1:0] rptr;
  logic [CMDQ_CNT_W-1:0] count;

  assign head       = entries[rptr];
  assign stat.full  = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

// ----- rtl/core/shdt_back.sv -----
// Back end: reduces the hash modulo the table size, accesses the slot store,
// runs fills and the clearing pass, and holds the result register.
// Depends on shdt_pkg and shdt_out_if.
module shdt_back (
  input  logic                      clk,
  input  logic                      rst,
  input  shdt_pkg::cmd_t            head,
  input  shdt_pkg::q_status_t       q_stat,
  output logic                      pop,
  output logic                      clearing,
  input  logic [shdt_pkg::SIZE_W-1:0] table_size,
  input  logic                      pointer_mode,
  shdt_out_if.source                rsp
);
  import shdt_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [HASH_W-1:0]      div_hash;
  logic [SIZE_W-1:0]      rem;
  logic [SIZE_W-1:0]      rem_next;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [OP_W-1:0]        cmd_op;
  logic [VALUE_WIDTH-1:0] cmd_value;
  logic [SIZE_W-1:0]      fill_cnt;
  logic [SLOT_W-1:0]      clr_cnt;
  logic [SIZE_W-1:0]      size_eff;
  logic                   op_ok;
  logic                   op_write;
  logic                   op_read;
  logic                   op_fill;
  logic                   rd_sel;
  logic                   ok_q;

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   mem_we;
  logic                   mem_re;
  logic [SLOT_W-1:0]      mem_addr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  logic                   out_valid;
  logic                   out_ok;
  logic [63:0]            out_read;
  logic [SLOT_OUT_W-1:0]  out_slot;
  logic                   out_free;
  logic                   out_load;

  assign rsp.valid      = out_valid;
  assign rsp.ok         = out_ok;
  assign rsp.read_value = out_read;
  assign rsp.slot       = out_slot;
  assign out_free       = !out_valid || rsp.ready;

  always_comb begin
    if (table_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (32'(table_size) > TABLE_DEPTH) begin
      size_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_eff = table_size;
    end
  end

  always_comb begin
    logic [SIZE_W:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[SIZE_W-1:0], div_hash[HASH_W-1-i]};
      if (r >= {1'b0, size_eff}) begin
        r = r - {1'b0, size_eff};
      end
    end
    rem_next = r[SIZE_W-1:0];
  end

  always_comb begin
    op_ok    = 1'b0;
    op_write = 1'b0;
    op_read  = 1'b0;
    op_fill  = 1'b0;
    unique case (cmd_op)
      OP_SET: begin
        op_ok    = !pointer_mode;
        op_write = !pointer_mode;
      end
      OP_SET_PTR: begin
        op_ok    = pointer_mode;
        op_write = pointer_mode;
      end
      OP_GET: begin
        op_ok   = !pointer_mode;
        op_read = !pointer_mode;
      end
      OP_GET_PTR: begin
        op_ok   = pointer_mode;
        op_read = pointer_mode;
      end
      OP_FILL: begin
        op_ok   = !pointer_mode;
        op_fill = !pointer_mode;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_cnt == SLOT_W'(TABLE_DEPTH - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_stat.empty) state_next = BK_DIV;
      end
      BK_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = BK_ACCESS;
      end
      BK_ACCESS: begin
        state_next = op_fill ? BK_FILL : BK_DONE;
      end
      BK_FILL: begin
        if (fill_cnt == size_eff - 1'b1) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    clearing  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = SLOT_W'(rem);
    mem_wdata = cmd_value;
    out_load  = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      BK_IDLE: begin
        pop = !q_stat.empty;
      end
      BK_DIV: begin
      end
      BK_ACCESS: begin
        mem_we = op_write;
        mem_re = op_read;
      end
      BK_FILL: begin
        mem_we   = 1'b1;
        mem_addr = SLOT_W'(fill_cnt);
      end
      BK_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      div_hash  <= head.hash;
      cmd_op    <= head.op;
      cmd_value <= head.value;
      rem       <= '0;
      div_cnt   <= '0;
    end
    if (state == BK_DIV) begin
      div_hash <= div_hash << DIV_BITS;
      rem      <= rem_next;
      div_cnt  <= div_cnt + 1'b1;
    end
    if (state == BK_ACCESS) begin
      rd_sel   <= op_read;
      ok_q     <= op_ok;
      fill_cnt <= '0;
    end
    if (state == BK_FILL) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
    if (out_load) begin
      out_ok   <= ok_q;
      out_read <= rd_sel ? 64'(mem_rdata) : 64'd0;
      out_slot <= (cmd_op == OP_FILL) ? '0 : SLOT_OUT_W'(rem);
    end
  end

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == BK_CLEAR |-> !out_valid && !pop)
    else $error("result or queue pop during clearing pass");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result register not valid after load");

  a_pop_divides: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == BK_DIV)
    else $error("popped command did not start the modulo");

  a_access_done: assert property (@(posedge clk) disable iff (rst)
    (state == BK_ACCESS && !op_fill) |=> state == BK_DONE)
    else $error("single-slot access did not go to result");

endmodule

// ----- rtl/core/string_hash_direct_table_unit.sv -----
// Direct-mapped string hash table. A nonzero name byte is folded into the
// hash. A terminating byte's result comes from the modulo unit (8 hash bits
// per cycle) and the registered slot read; a fill writes every slot in use.
// After reset the store is cleared, during which no byte is accepted.
// Depends on shdt_pkg, shdt_if.
module string_hash_direct_table_unit (
  input  logic                               clk,
  input  logic                               rst,
  shdt_in_if.sink                            req,
  shdt_out_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [shdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [shdt_pkg::SIZE_W-1:0]        cfg_data
);
  import shdt_pkg::*;

  logic [SIZE_W-1:0] table_size;
  logic              pointer_mode;
  logic              push;
  logic              pop;
  logic              clearing;
  cmd_t              push_cmd;
  cmd_t              head;
  q_status_t         q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= SIZE_W'(TABLE_SIZE_RESET);
      pointer_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TABLE_SIZE:   table_size   <= cfg_data;
        REG_POINTER_MODE: pointer_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  shdt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .q_stat   (q_stat),
    .clearing (clearing),
    .push     (push),
    .push_cmd (push_cmd)
  );

  shdt_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .head  (head),
    .stat  (q_stat)
  );

  shdt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .clearing     (clearing),
    .table_size   (table_size),
    .pointer_mode (pointer_mode),
    .rsp          (rsp)
  );

endmodule
